// File: hw/rtl/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared constants and the arctangent table of the triangle solid angle unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tsa_pkg;

   // width of the result angle
   localparam int ANGLE_WIDTH = 16;

   // angle accumulator, q30 radians with headroom for the quadrant fold
   localparam int ZW = 35;

   // cordic datapath width, the larger operand magnitude sits in [2^40, 2^41) on entry
   localparam int CXW = 44;

   // normalisation target: largest magnitude ends in [2^40, 2^41)
   localparam int NORM_LOW_BIT = 40;

   localparam int CORDIC_STEPS = 28;
   localparam int Q_BITS = 30;

   localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;

   // atan(2^-i) in q30, fraction truncated except the last entry, which is rounded
   localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008
   };

endpackage

`default_nettype wire

// File: hw/rtl/tsa_if.sv
// ----------------------------------------------------------------------------
// tsa request and response channels
// Valid/ready channels carrying one point-triangle request and one angle.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsa_req_if #(parameter int COORD_WIDTH = 16);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] point_z;
   logic signed [COORD_WIDTH-1:0] vert_a_x;
   logic signed [COORD_WIDTH-1:0] vert_a_y;
   logic signed [COORD_WIDTH-1:0] vert_a_z;
   logic signed [COORD_WIDTH-1:0] vert_b_x;
   logic signed [COORD_WIDTH-1:0] vert_b_y;
   logic signed [COORD_WIDTH-1:0] vert_b_z;
   logic signed [COORD_WIDTH-1:0] vert_c_x;
   logic signed [COORD_WIDTH-1:0] vert_c_y;
   logic signed [COORD_WIDTH-1:0] vert_c_z;

   modport source (output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
                   vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
                   input ready);
   modport sink (input valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
                 vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
                 output ready);
endinterface

interface tsa_rsp_if;
   import tsa_pkg::*;
   logic valid;
   logic ready;
   logic signed [ANGLE_WIDTH-1:0] half_solid_angle;

   modport source (output valid, half_solid_angle, input ready);
   modport sink (input valid, half_solid_angle, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tsa_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tsa_sqrt_cell
// One digit of a radix-2 restoring integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_sqrt_cell #(
   parameter int SSW = 34,
   parameter int J = 16
) (
   input  logic           clock,
   input  logic           enable,
   input  logic [SSW-1:0] rem_in,
   input  logic [SSW:0]   res_in,
   output logic [SSW-1:0] rem_ff,
   output logic [SSW:0]   res_ff
);
   localparam logic [SSW:0] BIT = (SSW+1)'(1) << (2 * J);

   logic [SSW:0]   trial;
   logic [SSW-1:0] rem_nx_in;
   logic [SSW:0]   res_nx_in;

   // trial subtract of the current digit
   always_comb begin
      trial = res_in + BIT;
      if ({1'b0, rem_in} >= trial) begin
         rem_nx_in = rem_in - trial[SSW-1:0];
         res_nx_in = (res_in >> 1) + BIT;
      end else begin
         rem_nx_in = rem_in;
         res_nx_in = res_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_nx_in;
         res_ff <= res_nx_in;
      end
   end
endmodule

`default_nettype wire

// File: hw/rtl/tsa_norm_cell.sv
// ----------------------------------------------------------------------------
// tsa_norm_cell
// One binary step of the operand normalisation ahead of the cordic row.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_norm_cell #(
   parameter int NW = 56,
   parameter int SHIFT = 1,
   parameter bit LEFT = 1'b1
) (
   input  logic clock,
   input  logic reset,
   input  logic enable,
   input  logic valid_in,
   input  logic zero_in,
   input  logic signed [tsa_pkg::ZW-1:0] z_in,
   input  logic signed [NW-1:0] x_in,
   input  logic signed [NW-1:0] y_in,
   input  logic [NW-1:0] m_in,
   output logic valid_ff,
   output logic zero_ff,
   output logic signed [tsa_pkg::ZW-1:0] z_ff,
   output logic signed [NW-1:0] x_ff,
   output logic signed [NW-1:0] y_ff,
   output logic [NW-1:0] m_ff
);
   import tsa_pkg::*;

   localparam int LIM_BIT = LEFT ? (NORM_LOW_BIT + 1 - SHIFT) : (NORM_LOW_BIT + SHIFT);
   localparam logic [NW-1:0] LIMIT = NW'(1) << LIM_BIT;

   logic take;

   // shift when the shift cannot carry the magnitude past the far edge of the target band
   assign take = LEFT ? (m_in < LIMIT) : (m_in >= LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         zero_ff <= zero_in;
         z_ff    <= z_in;
         if (take && LEFT) begin
            x_ff <= x_in <<< SHIFT;
            y_ff <= y_in <<< SHIFT;
            m_ff <= m_in << SHIFT;
         end else if (take) begin
            x_ff <= x_in >>> SHIFT;
            y_ff <= y_in >>> SHIFT;
            m_ff <= m_in >> SHIFT;
         end else begin
            x_ff <= x_in;
            y_ff <= y_in;
            m_ff <= m_in;
         end
      end
   end
endmodule

`default_nettype wire

// File: hw/rtl/tsa_cordic_cell.sv
// ----------------------------------------------------------------------------
// tsa_cordic_cell
// One vectoring rotation of the cordic row with its own fixed shift.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic enable,
   input  logic valid_in,
   input  logic zero_in,
   input  logic signed [tsa_pkg::CXW-1:0] x_in,
   input  logic signed [tsa_pkg::CXW-1:0] y_in,
   input  logic signed [tsa_pkg::ZW-1:0] z_in,
   output logic valid_ff,
   output logic zero_ff,
   output logic signed [tsa_pkg::CXW-1:0] x_ff,
   output logic signed [tsa_pkg::CXW-1:0] y_ff,
   output logic signed [tsa_pkg::ZW-1:0] z_ff
);
   import tsa_pkg::*;

   localparam logic signed [ZW-1:0] ANGLE = $signed({3'b000, ATAN_Q30[STEP]});

   logic signed [CXW-1:0] xs;
   logic signed [CXW-1:0] ys;

   assign xs = x_in >>> STEP;
   assign ys = y_in >>> STEP;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // rotate towards the x axis
   always_ff @(posedge clock) begin
      if (enable) begin
         zero_ff <= zero_in;
         if (!y_in[CXW-1]) begin
            x_ff <= x_in + ys;
            y_ff <= y_in - xs;
            z_ff <= z_in + ANGLE;
         end else begin
            x_ff <= x_in - ys;
            y_ff <= y_in + xs;
            z_ff <= z_in - ANGLE;
         end
      end
   end
endmodule

`default_nettype wire

// File: hw/rtl/triangle_solid_angle_unit.sv
// ----------------------------------------------------------------------------
// triangle_solid_angle_unit
// Half the solid angle a triangle subtends at a point, atan2(det, den).
// ----------------------------------------------------------------------------
// Fully pipelined: one request is taken every cycle and each answer passes
// through a fixed COORD_WIDTH + 43 register stages plus one per right
// normalisation step (63 stages at the defaults). The latency is set by the
// row of COORD_WIDTH+1 square-root digit cells, the row of up to ten
// normalisation cells and the row of 28 cordic cells. The whole pipe stalls
// only when the result register is full and not taken.
`default_nettype none

module triangle_solid_angle_unit #(
   parameter int COORD_WIDTH = 16,
   parameter int ANGLE_FRAC_BITS = 13
) (
   input logic clock,
   input logic reset,
   tsa_req_if.sink req_chan,
   tsa_rsp_if.source rsp_chan
);
   import tsa_pkg::*;

   localparam int DW  = COORD_WIDTH + 1;
   localparam int PW  = 2 * DW;
   localparam int SSW = 2 * COORD_WIDTH + 2;
   localparam int RW  = COORD_WIDTH + 1;
   localparam int CRW = PW + 1;
   localparam int DTW = PW + 2;
   localparam int W   = 3 * COORD_WIDTH + 8;
   localparam int NW  = (W > CXW) ? W : CXW;
   localparam int NSTG = 10;

   logic adv;
   logic out_valid_ff;
   logic signed [ANGLE_WIDTH-1:0] out_angle_ff;

   // whole pipe advances unless the result register is blocked
   assign adv = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // edge vectors
   logic signed [DW-1:0] d1_ff [9];
   logic v1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff[0] <= DW'(req_chan.vert_a_x) - DW'(req_chan.point_x);
         d1_ff[1] <= DW'(req_chan.vert_a_y) - DW'(req_chan.point_y);
         d1_ff[2] <= DW'(req_chan.vert_a_z) - DW'(req_chan.point_z);
         d1_ff[3] <= DW'(req_chan.vert_b_x) - DW'(req_chan.point_x);
         d1_ff[4] <= DW'(req_chan.vert_b_y) - DW'(req_chan.point_y);
         d1_ff[5] <= DW'(req_chan.vert_b_z) - DW'(req_chan.point_z);
         d1_ff[6] <= DW'(req_chan.vert_c_x) - DW'(req_chan.point_x);
         d1_ff[7] <= DW'(req_chan.vert_c_y) - DW'(req_chan.point_y);
         d1_ff[8] <= DW'(req_chan.vert_c_z) - DW'(req_chan.point_z);
      end
   end

   // products: squares, cross-product partials, dot-product partials
   logic signed [PW-1:0] sq2_ff [9];
   logic signed [PW-1:0] xp2_ff [6];
   logic signed [PW-1:0] dp2_ff [9];
   logic signed [DW-1:0] a2_ff [3];
   logic v2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 9; i++) begin
            sq2_ff[i] <= d1_ff[i] * d1_ff[i];
         end
         xp2_ff[0] <= d1_ff[4] * d1_ff[8];
         xp2_ff[1] <= d1_ff[5] * d1_ff[7];
         xp2_ff[2] <= d1_ff[3] * d1_ff[8];
         xp2_ff[3] <= d1_ff[5] * d1_ff[6];
         xp2_ff[4] <= d1_ff[3] * d1_ff[7];
         xp2_ff[5] <= d1_ff[4] * d1_ff[6];
         for (int i = 0; i < 3; i++) begin
            dp2_ff[i]     <= d1_ff[i] * d1_ff[3+i];
            dp2_ff[3 + i] <= d1_ff[i] * d1_ff[6+i];
            dp2_ff[6 + i] <= d1_ff[3+i] * d1_ff[6+i];
            a2_ff[i]      <= d1_ff[i];
         end
      end
   end

   // squared lengths, cross product, dot products
   logic [SSW-1:0] ss3_ff [3];
   logic signed [CRW-1:0] cr3_ff [3];
   logic signed [DTW-1:0] dt3_ff [3];
   logic signed [DW-1:0] a3_ff [3];
   logic v3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            ss3_ff[i] <= SSW'($unsigned(sq2_ff[3*i])) + SSW'($unsigned(sq2_ff[3*i+1]))
                         + SSW'($unsigned(sq2_ff[3*i+2]));
            cr3_ff[i] <= CRW'(xp2_ff[2*i]) - CRW'(xp2_ff[2*i+1]);
            dt3_ff[i] <= DTW'(dp2_ff[3*i]) + DTW'(dp2_ff[3*i+1]) + DTW'(dp2_ff[3*i+2]);
            a3_ff[i]  <= a2_ff[i];
         end
      end
   end

   // triple product terms and sum
   logic signed [DW+CRW-1:0] dprod [3];
   logic signed [W-1:0] dt4_ff [3];
   logic signed [W-1:0] det5_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dprod[i] = a3_ff[i] * cr3_ff[i];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dt4_ff[i] <= W'(dprod[i]);
         end
         det5_ff <= dt4_ff[0] - dt4_ff[1] + dt4_ff[2];
      end
   end

   // square-root rows, one digit per cell
   logic [SSW-1:0] sq_rem [3][RW+1];
   logic [SSW:0]   sq_res [3][RW+1];
   for (genvar r = 0; r < 3; r++) begin : g_sqrt_row
      assign sq_rem[r][0] = ss3_ff[r];
      assign sq_res[r][0] = '0;
      for (genvar k = 0; k < RW; k++) begin : g_cell
         tsa_sqrt_cell #(.SSW(SSW), .J(COORD_WIDTH - k)) u_cell (
            .clock  (clock),
            .enable (adv),
            .rem_in (sq_rem[r][k]),
            .res_in (sq_res[r][k]),
            .rem_ff (sq_rem[r][k+1]),
            .res_ff (sq_res[r][k+1])
         );
      end
   end

   // delay lines alongside the square-root rows
   logic vq_ff [RW];
   logic signed [DTW-1:0] dtd_ff [RW][3];
   logic signed [W-1:0] detd_ff [RW-2];
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int k = 0; k < RW; k++) begin
            vq_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vq_ff[0] <= v3_ff;
         for (int k = 1; k < RW; k++) begin
            vq_ff[k] <= vq_ff[k-1];
         end
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         dtd_ff[0] <= dt3_ff;
         for (int k = 1; k < RW; k++) begin
            dtd_ff[k] <= dtd_ff[k-1];
         end
         detd_ff[0] <= det5_ff;
         for (int k = 1; k < RW - 2; k++) begin
            detd_ff[k] <= detd_ff[k-1];
         end
      end
   end

   // denominator
   logic signed [RW:0] la, lb, lc;
   assign la = $signed({1'b0, sq_res[0][RW][RW-1:0]});
   assign lb = $signed({1'b0, sq_res[1][RW][RW-1:0]});
   assign lc = $signed({1'b0, sq_res[2][RW][RW-1:0]});

   logic signed [DTW+RW:0] tab, tac, tbc;
   assign tab = dtd_ff[RW-1][0] * lc;
   assign tac = dtd_ff[RW-1][1] * lb;
   assign tbc = dtd_ff[RW-1][2] * la;

   logic [2*RW-1:0] lab1_ff;
   logic [RW-1:0] lc1_ff;
   logic signed [W-1:0] t1_ff [3];
   logic signed [W-1:0] det1_ff, det2_ff, det3_ff;
   logic [3*RW-1:0] p2_ff;
   logic signed [W-1:0] s2_ff;
   logic signed [W-1:0] den3_ff;
   logic vd1_ff, vd2_ff, vd3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         lab1_ff <= sq_res[0][RW][RW-1:0] * sq_res[1][RW][RW-1:0];
         lc1_ff  <= sq_res[2][RW][RW-1:0];
         t1_ff[0] <= W'(tab);
         t1_ff[1] <= W'(tac);
         t1_ff[2] <= W'(tbc);
         det1_ff <= detd_ff[RW-3];
         p2_ff   <= lab1_ff * lc1_ff;
         s2_ff   <= t1_ff[0] + t1_ff[1] + t1_ff[2];
         det2_ff <= det1_ff;
         den3_ff <= $signed(W'(p2_ff)) + s2_ff;
         det3_ff <= det2_ff;
      end
   end

   // quadrant fold and magnitude
   logic signed [NW-1:0] fx_in, fy_in;
   logic [NW-1:0] fm_in;
   logic signed [ZW-1:0] fz_in;
   logic fzero_in;
   always_comb begin
      fzero_in = (den3_ff == '0) && (det3_ff == '0);
      if (den3_ff[W-1]) begin
         fx_in = -NW'(den3_ff);
         fy_in = -NW'(det3_ff);
         fz_in = det3_ff[W-1] ? -PI_Q30 : PI_Q30;
      end else begin
         fx_in = NW'(den3_ff);
         fy_in = NW'(det3_ff);
         fz_in = '0;
      end
      fm_in = $unsigned(fx_in);
      if (fy_in[NW-1] && ($unsigned(-fy_in) > fm_in)) begin
         fm_in = $unsigned(-fy_in);
      end else if (!fy_in[NW-1] && ($unsigned(fy_in) > fm_in)) begin
         fm_in = $unsigned(fy_in);
      end
   end

   logic vf_ff, zf_ff;
   logic signed [NW-1:0] xf_ff, yf_ff;
   logic [NW-1:0] mf_ff;
   logic signed [ZW-1:0] zf_z_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         zf_ff   <= fzero_in;
         xf_ff   <= fx_in;
         yf_ff   <= fy_in;
         mf_ff   <= fm_in;
         zf_z_ff <= fz_in;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         vd1_ff <= 1'b0;
         vd2_ff <= 1'b0;
         vd3_ff <= 1'b0;
         vf_ff  <= 1'b0;
      end else if (adv) begin
         vd1_ff <= vq_ff[RW-1];
         vd2_ff <= vd1_ff;
         vd3_ff <= vd2_ff;
         vf_ff  <= vd3_ff;
      end
   end

   // normalisation row: six left-shift steps, then right-shift steps
   logic nv [NSTG+1];
   logic nz [NSTG+1];
   logic signed [ZW-1:0] nzz [NSTG+1];
   logic signed [NW-1:0] nx [NSTG+1];
   logic signed [NW-1:0] ny [NSTG+1];
   logic [NW-1:0] nm [NSTG+1];
   assign nv[0] = vf_ff;
   assign nz[0] = zf_ff;
   assign nzz[0] = zf_z_ff;
   assign nx[0] = xf_ff;
   assign ny[0] = yf_ff;
   assign nm[0] = mf_ff;
   for (genvar k = 0; k < NSTG; k++) begin : g_norm
      localparam bit IS_LEFT = (k < 6);
      localparam int SH = IS_LEFT ? (32 >> k) : (8 >> (k - 6));
      if (IS_LEFT || (NORM_LOW_BIT + SH < NW - 1)) begin : g_cell
         tsa_norm_cell #(.NW(NW), .SHIFT(SH), .LEFT(IS_LEFT)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .enable   (adv),
            .valid_in (nv[k]),
            .zero_in  (nz[k]),
            .z_in     (nzz[k]),
            .x_in     (nx[k]),
            .y_in     (ny[k]),
            .m_in     (nm[k]),
            .valid_ff (nv[k+1]),
            .zero_ff  (nz[k+1]),
            .z_ff     (nzz[k+1]),
            .x_ff     (nx[k+1]),
            .y_ff     (ny[k+1]),
            .m_ff     (nm[k+1])
         );
      end else begin : g_skip
         assign nv[k+1]  = nv[k];
         assign nz[k+1]  = nz[k];
         assign nzz[k+1] = nzz[k];
         assign nx[k+1]  = nx[k];
         assign ny[k+1]  = ny[k];
         assign nm[k+1]  = nm[k];
      end
   end

   // cordic row
   logic cv [CORDIC_STEPS+1];
   logic cz0 [CORDIC_STEPS+1];
   logic signed [CXW-1:0] cx [CORDIC_STEPS+1];
   logic signed [CXW-1:0] cy [CORDIC_STEPS+1];
   logic signed [ZW-1:0] cz [CORDIC_STEPS+1];
   assign cv[0]  = nv[NSTG];
   assign cz0[0] = nz[NSTG];
   assign cx[0]  = nx[NSTG][CXW-1:0];
   assign cy[0]  = ny[NSTG][CXW-1:0];
   assign cz[0]  = nzz[NSTG];
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      tsa_cordic_cell #(.STEP(k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (adv),
         .valid_in (cv[k]),
         .zero_in  (cz0[k]),
         .x_in     (cx[k]),
         .y_in     (cy[k]),
         .z_in     (cz[k]),
         .valid_ff (cv[k+1]),
         .zero_ff  (cz0[k+1]),
         .x_ff     (cx[k+1]),
         .y_ff     (cy[k+1]),
         .z_ff     (cz[k+1])
      );
   end

   // round to the output grid, halves up
   logic signed [ZW-1:0] zr;
   logic signed [ZW-1:0] zq;
   assign zr = cz[CORDIC_STEPS] + (ZW'(1) <<< (Q_BITS - 1 - ANGLE_FRAC_BITS));
   assign zq = zr >>> (Q_BITS - ANGLE_FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= cv[CORDIC_STEPS];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_angle_ff <= cz0[CORDIC_STEPS] ? '0 : zq[ANGLE_WIDTH-1:0];
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.half_solid_angle = out_angle_ff;

   // an empty result register never blocks a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_chan.ready)
      else $error("request refused with an empty result register");

   // folded x operand is never negative
   a_fold_positive: assert property (@(posedge clock) disable iff (reset)
      vf_ff |-> !xf_ff[NW-1])
      else $error("quadrant fold left a negative x");

   // operands enter the cordic row inside the target band
   a_norm_band: assert property (@(posedge clock) disable iff (reset)
      (nv[NSTG] && !nz[NSTG]) |->
         (nm[NSTG] >= (NW'(1) << NORM_LOW_BIT)) && (nm[NSTG] < (NW'(1) << (NORM_LOW_BIT + 1))))
      else $error("normalisation out of band");

   // a result only appears when the pipe advanced
   a_out_on_adv: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(adv))
      else $error("result appeared during a stall");
endmodule

`default_nettype wire
